// File: rtl/igs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// igs_pkg
// Shared widths and register indexes for the image gradient stencil.
// ----------------------------------------------------------------------------
package igs_pkg;

  localparam int PIX_W      = 16;  // pixel field on the ports
  localparam int GRAD_W     = 19;  // derivative fields, quarter units
  localparam int ROWS_W     = 11;  // rows_in_use register
  localparam int COLS_W     = 16;  // cols_in_use register
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd1;

  localparam int GRAD_MAX = 262143;
  localparam int GRAD_MIN = -262144;

endpackage

// File: rtl/igs_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// igs_if
// Valid/ready channels: pixel input, result output, register writes.
// ----------------------------------------------------------------------------
interface igs_pix_if;
  logic                      valid;
  logic                      ready;
  logic [igs_pkg::PIX_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface igs_res_if;
  logic                              valid;
  logic                              ready;
  logic [igs_pkg::PIX_W-1:0]         pixel_value;
  logic signed [igs_pkg::GRAD_W-1:0] grad_x;
  logic signed [igs_pkg::GRAD_W-1:0] grad_y;
  logic signed [igs_pkg::GRAD_W-1:0] grad_xy;
  logic                              frame_end;

  modport source (output valid, output pixel_value, output grad_x, output grad_y,
                  output grad_xy, output frame_end, input ready);
  modport sink   (input valid, input pixel_value, input grad_x, input grad_y,
                  input grad_xy, input frame_end, output ready);
endinterface

interface igs_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [igs_pkg::CFG_IDX_W-1:0]  index;
  logic [igs_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/igs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// igs_ram
// Simple dual-port RAM, one write and one registered read port.
// Read of the address being written returns the old data.
// ----------------------------------------------------------------------------
module igs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

// File: rtl/image_gradient_stencil_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// image_gradient_stencil_core
// Streaming finite-difference gradient (x, y, xy) over a column-major image.
// ----------------------------------------------------------------------------
// Pixels arrive down each column, then the next column; one pixel is taken
// per clock while results are accepted. Two column banks (one RAM each,
// MAX_ROWS deep) hold the last two columns: every pixel reads the same row
// from both banks and overwrites the older bank, so a 3x3 window of the last
// three rows of the last three columns slides along. Each result carries the
// center sample and grad_x, grad_y, grad_xy in quarter units (halved central
// differences inside, one-sided differences on edges, cross term /4 inside
// and /2 on edges). A result leaves one column and one row after its pixel;
// the last column is flushed as it arrives, so there each pixel below the
// top row gives two results (four on the final pixel) and the input is held
// for the extra result beats.
// Sustained rate: one pixel per clock while results are taken and no extra
// beats are pending, set by the single result register (one result beat per
// clock). Pixels pass RAM read, window update and result register. Writing
// either size register restarts the frame; the block must be idle then.
// Sizes act as clamped: rows to [2, MAX_ROWS], columns to at least 2.
// ----------------------------------------------------------------------------
module image_gradient_stencil_core #(
  parameter int MAX_ROWS   = 1024,
  parameter int PIXEL_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  igs_cfg_if.sink   cfg,
  igs_pix_if.sink   pix_in,
  igs_res_if.source res_out
);

  localparam int PW   = PIXEL_BITS;
  localparam int RIW  = $clog2(MAX_ROWS);                  // row index bits
  localparam int RCW0 = $clog2(MAX_ROWS + 1);
  localparam int RCW  = (RCW0 > igs_pkg::ROWS_W) ? RCW0 : igs_pkg::ROWS_W;
  localparam int GW   = PW + 5;                            // derivative math
  localparam int SW   = (GW > igs_pkg::GRAD_W + 1) ? GW : igs_pkg::GRAD_W + 1;
  localparam int CW   = igs_pkg::COLS_W;

  // result kinds, in emission order
  localparam int K_INNER    = 0;  // (r-1, c-1)
  localparam int K_LASTCOL  = 1;  // (r-1, c) on the last column
  localparam int K_LASTROW  = 2;  // (r, c-1) on the last row
  localparam int K_CORNER   = 3;  // (r, c) final pixel of the frame

  typedef struct packed {
    logic [3:0] kinds;  // results this pixel releases
    logic       xint;   // interior in x (column >= 2)
    logic       yint;   // interior in y (row >= 2)
  } ctl_t;

  // --------------------------------------------------------------------------
  // configuration
  // --------------------------------------------------------------------------
  logic [igs_pkg::ROWS_W-1:0] rows_in_use;
  logic [CW-1:0]              cols_in_use;
  logic                       cfg_hit;

  assign cfg.ready = 1'b1;
  assign cfg_hit   = cfg.valid &&
                     (cfg.index == igs_pkg::CFG_ROWS || cfg.index == igs_pkg::CFG_COLS);

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= igs_pkg::ROWS_W'(1024);
      cols_in_use <= CW'(1024);
    end else if (cfg.valid) begin
      if (cfg.index == igs_pkg::CFG_ROWS) begin
        rows_in_use <= cfg.data[igs_pkg::ROWS_W-1:0];
      end
      if (cfg.index == igs_pkg::CFG_COLS) begin
        cols_in_use <= cfg.data[CW-1:0];
      end
    end
  end

  // effective sizes as last indexes
  logic [RCW-1:0] rows_ext;
  logic [RCW-1:0] rows_eff;
  logic [RIW-1:0] row_last;
  logic [CW-1:0]  col_last;

  always_comb begin
    rows_ext = RCW'(rows_in_use);
    if (rows_ext < RCW'(2)) begin
      rows_eff = RCW'(2);
    end else if (rows_ext > RCW'(MAX_ROWS)) begin
      rows_eff = RCW'(MAX_ROWS);
    end else begin
      rows_eff = rows_ext;
    end
    row_last = RIW'(rows_eff - RCW'(1));
    col_last = (cols_in_use < CW'(2)) ? CW'(1) : cols_in_use - CW'(1);
  end

  // --------------------------------------------------------------------------
  // handshake chain: accept -> s1 (RAM read) -> s2 (window) -> result reg
  // --------------------------------------------------------------------------
  logic           s1_valid;
  logic [PW-1:0]  s1_pix;
  logic           s1_bank;
  ctl_t           s1_ctl;
  logic           s2_valid;
  ctl_t           s2_ctl;
  logic           out_free;
  logic [3:0]     sel;
  logic [3:0]     kinds_after;
  logic           s2_emit;
  logic           s2_done;
  logic           s2_free;
  logic           s1_move;
  logic           in_accept;

  assign out_free    = !res_out.valid || res_out.ready;
  assign sel         = s2_ctl.kinds & (~s2_ctl.kinds + 4'd1);  // lowest pending
  assign kinds_after = s2_ctl.kinds & ~sel;
  assign s2_emit     = s2_valid && (s2_ctl.kinds != 4'd0) && out_free;
  assign s2_done     = s2_valid && ((s2_ctl.kinds == 4'd0) ||
                                    (out_free && kinds_after == 4'd0));
  assign s2_free     = !s2_valid || s2_done;
  assign s1_move     = s1_valid && s2_free;
  assign pix_in.ready = !s1_valid || s1_move;
  assign in_accept   = pix_in.valid && pix_in.ready;

  // --------------------------------------------------------------------------
  // frame position and per-pixel control
  // --------------------------------------------------------------------------
  logic [RIW-1:0]  row_pos;
  logic [CW-1:0]   col_pos;
  logic            at_last_row;
  logic            at_last_col;
  logic            past_col0;
  ctl_t            ctl_new;
  logic [PW+15:0]  pix_wide;
  logic [PW-1:0]   pix_kept;

  always_comb begin
    at_last_row = (row_pos == row_last);
    at_last_col = (col_pos == col_last);
    past_col0   = (col_pos != CW'(0));
    ctl_new.kinds[K_INNER]   = past_col0 && (row_pos != RIW'(0));
    ctl_new.kinds[K_LASTCOL] = past_col0 && (row_pos != RIW'(0)) && at_last_col;
    ctl_new.kinds[K_LASTROW] = past_col0 && at_last_row;
    ctl_new.kinds[K_CORNER]  = past_col0 && at_last_row && at_last_col;
    ctl_new.xint = (col_pos >= CW'(2));
    ctl_new.yint = (RCW'(row_pos) >= RCW'(2));
    pix_wide = {PW'(0), pix_in.pixel};
    pix_kept = pix_wide[PW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_pos <= '0;
      col_pos <= '0;
    end else if (cfg_hit) begin
      row_pos <= '0;
      col_pos <= '0;
    end else if (in_accept) begin
      if (at_last_row) begin
        row_pos <= '0;
        col_pos <= at_last_col ? CW'(0) : col_pos + CW'(1);
      end else begin
        row_pos <= row_pos + RIW'(1);
      end
    end
  end

  // --------------------------------------------------------------------------
  // column banks: bank col[0] holds column c-2, the other column c-1
  // --------------------------------------------------------------------------
  logic [PW-1:0] bank0_rd;
  logic [PW-1:0] bank1_rd;

  igs_ram #(.WIDTH(PW), .DEPTH(MAX_ROWS)) u_bank0 (
    .clk   (clk),
    .we    (in_accept && !col_pos[0]),
    .waddr (row_pos),
    .wdata (pix_kept),
    .re    (in_accept),
    .raddr (row_pos),
    .rdata (bank0_rd)
  );

  igs_ram #(.WIDTH(PW), .DEPTH(MAX_ROWS)) u_bank1 (
    .clk   (clk),
    .we    (in_accept && col_pos[0]),
    .waddr (row_pos),
    .wdata (pix_kept),
    .re    (in_accept),
    .raddr (row_pos),
    .rdata (bank1_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_pix  <= pix_kept;
      s1_bank <= col_pos[0];
      s1_ctl  <= ctl_new;
    end
  end

  // --------------------------------------------------------------------------
  // 3x3 window: win[column oldest..newest][row oldest..newest]
  // --------------------------------------------------------------------------
  logic [PW-1:0] win [3][3];

  always_ff @(posedge clk) begin
    if (s1_move) begin
      for (int k = 0; k < 3; k++) begin
        win[k][0] <= win[k][1];
        win[k][1] <= win[k][2];
      end
      win[0][2] <= s1_bank ? bank1_rd : bank0_rd;
      win[1][2] <= s1_bank ? bank0_rd : bank1_rd;
      win[2][2] <= s1_pix;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_move) begin
      s2_valid <= 1'b1;
    end else if (s2_done) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      s2_ctl <= s1_ctl;
    end else if (s2_emit) begin
      s2_ctl.kinds <= kinds_after;
    end
  end

  // --------------------------------------------------------------------------
  // derivatives for the selected result
  // --------------------------------------------------------------------------
  function automatic logic [igs_pkg::GRAD_W-1:0] sat_grad(input logic signed [GW-1:0] v);
    logic signed [SW-1:0] w;
    logic signed [SW-1:0] r;
    w = SW'(v);
    if (w > SW'(igs_pkg::GRAD_MAX)) begin
      r = SW'(igs_pkg::GRAD_MAX);
    end else if (w < SW'(igs_pkg::GRAD_MIN)) begin
      r = SW'(igs_pkg::GRAD_MIN);
    end else begin
      r = w;
    end
    return r[igs_pkg::GRAD_W-1:0];
  endfunction

  logic                 new_col;   // center in newest column
  logic                 new_row;   // center in newest row
  logic                 xs_int;
  logic                 ys_int;
  logic [PW-1:0]        rowc [3];  // center row, per column
  logic [PW-1:0]        colc [3];  // center column, per row
  logic [PW-1:0]        xbcol [3]; // x back-tap column, per row
  logic [PW-1:0]        center;
  logic signed [GW-1:0] e_a;
  logic signed [GW-1:0] e_b;
  logic signed [GW-1:0] e_c;
  logic signed [GW-1:0] e_d;
  logic signed [GW-1:0] dx;
  logic signed [GW-1:0] dy;
  logic signed [GW-1:0] dxy;
  logic [PW+15:0]       center_wide;

  always_comb begin
    new_col = sel[K_LASTCOL] || sel[K_CORNER];
    new_row = sel[K_LASTROW] || sel[K_CORNER];
    xs_int  = (sel[K_INNER] || sel[K_LASTROW]) && s2_ctl.xint;
    ys_int  = (sel[K_INNER] || sel[K_LASTCOL]) && s2_ctl.yint;
    for (int k = 0; k < 3; k++) begin
      rowc[k]  = new_row ? win[k][2] : win[k][1];
      colc[k]  = new_col ? win[2][k] : win[1][k];
      xbcol[k] = xs_int ? win[0][k] : win[1][k];
    end
    center = new_row ? colc[2] : colc[1];

    e_a = GW'(rowc[2]);
    e_b = GW'(xs_int ? rowc[0] : rowc[1]);
    dx  = (e_a - e_b) <<< (xs_int ? 1 : 2);

    e_a = GW'(colc[2]);
    e_b = GW'(ys_int ? colc[0] : colc[1]);
    dy  = (e_a - e_b) <<< (ys_int ? 1 : 2);

    e_a = GW'(win[2][2]);
    e_b = GW'(ys_int ? win[2][0] : win[2][1]);
    e_c = GW'(xbcol[2]);
    e_d = GW'(ys_int ? xbcol[0] : xbcol[1]);
    dxy = (e_a - e_b - e_c + e_d) <<< ((xs_int && ys_int) ? 0 : 1);

    center_wide = {16'd0, center};
  end

  // --------------------------------------------------------------------------
  // result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      res_out.valid <= 1'b0;
    end else if (s2_emit) begin
      res_out.valid <= 1'b1;
    end else if (res_out.ready) begin
      res_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_emit) begin
      res_out.pixel_value <= center_wide[igs_pkg::PIX_W-1:0];
      res_out.grad_x      <= sat_grad(dx);
      res_out.grad_y      <= sat_grad(dy);
      res_out.grad_xy     <= sat_grad(dxy);
      res_out.frame_end   <= sel[K_CORNER];
    end
  end

endmodule
